@@ rtl/binary_heap_priority_queue_top_assert.svh @@
// Assertion macros for the binary heap priority queue.
// Used by the heap controller; no other dependencies.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define BHPQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// next-cycle implication
`define BHPQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`endif

@@ rtl/bhpq_pkg.sv @@
// Shared types, constants and compare function for the heap priority queue.
// No dependencies.
package bhpq_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_WIDTH  = 8;
   localparam int TAG_WIDTH  = 8;
   localparam int POS_WIDTH  = 6;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = ((ADDR_W > POS_WIDTH) ? ADDR_W : POS_WIDTH) + 2;
   localparam int ENTRY_W    = KEY_WIDTH + TAG_WIDTH;
   localparam int CSR_AW     = 3;

   localparam logic REG_ORDER_SELECT = 1'b0;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_POP    = 2'd1,
      MODE_UPDATE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_TOP,
      S_POP_LAST,
      S_UPD_RD,
      S_UP_START,
      S_UP_CMP,
      S_DN_START,
      S_DN_L,
      S_DN_R,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic [TAG_WIDTH-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // true if entry a must rise above entry b
   function automatic logic beats(entry_type a, entry_type b, logic order_sel);
      logic r;
      if (order_sel) begin
         r = a.key < b.key;
      end else begin
         r = a.key > b.key;
      end
      return r;
   endfunction

endpackage

@@ rtl/bhpq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bhpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bhpq_ctrl.sv @@
// Heap controller: sift-up and sift-down sequencer over the entry memory.
// Depends on bhpq_pkg and binary_heap_priority_queue_top_assert.svh.
`include "binary_heap_priority_queue_top_assert.svh"
module bhpq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            order_select,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [bhpq_pkg::KEY_WIDTH-1:0]  req_entry_key,
   input  logic [bhpq_pkg::TAG_WIDTH-1:0]  req_entry_tag,
   input  logic [bhpq_pkg::POS_WIDTH-1:0]  req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [bhpq_pkg::KEY_WIDTH-1:0]  rsp_out_key,
   output logic [bhpq_pkg::TAG_WIDTH-1:0]  rsp_out_tag,
   output bhpq_pkg::mem_req_type           mem_req,
   input  bhpq_pkg::entry_type             rd_data
);
   import bhpq_pkg::*;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    at_ff, at_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   entry_type            mov_ff, mov_in;
   entry_type            child_ff, child_in;
   logic                 upd_ff, upd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   status_type           status_ff, status_in;
   entry_type            out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   entry_type            rsp_out_ff, rsp_out_in;

   logic [IDX_W-1:0]  at_x, left_x, right_x, cnt_x, pos_x;
   logic [ADDR_W-1:0] parent;
   logic              accept;
   logic              decide;
   entry_type         cand;
   logic [ADDR_W-1:0] cand_idx;

   assign accept  = req_valid && !req_stall;
   assign at_x    = IDX_W'(at_ff);
   assign left_x  = (at_x << 1) + IDX_W'(1);
   assign right_x = left_x + IDX_W'(1);
   assign cnt_x   = IDX_W'(count_ff);
   assign pos_x   = IDX_W'(req_position);
   assign parent  = (at_ff - ADDR_W'(1)) >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      at_ff         <= at_in;
      mov_ff        <= mov_in;
      child_ff      <= child_in;
      upd_ff        <= upd_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      out_ff        <= out_in;
      rsp_status_ff <= rsp_status_in;
      rsp_out_ff    <= rsp_out_in;
   end

   always_comb begin
      state_in      = state_ff;
      at_in         = at_ff;
      count_in      = count_ff;
      mov_in        = mov_ff;
      child_in      = child_ff;
      upd_in        = upd_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      out_in        = out_ff;
      rsp_status_in = rsp_status_ff;
      rsp_out_in    = rsp_out_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_req       = '0;
      decide        = 1'b0;
      cand          = rd_data;
      cand_idx      = ADDR_W'(left_x);
      req_stall     = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = STAT_OK;
               out_in    = '0;
               state_in  = S_DONE;
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = STAT_FULL;
                     end else begin
                        mov_in   = '{key: req_entry_key, tag: req_entry_tag};
                        at_in    = ADDR_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                        upd_in   = 1'b0;
                        state_in = S_UP_START;
                     end
                  end
                  MODE_POP: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        count_in      = count_ff - CNT_W'(1);
                        mem_req.raddr = '0;
                        state_in      = S_POP_TOP;
                     end
                  end
                  MODE_UPDATE: begin
                     if (pos_x >= cnt_x) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        at_in         = ADDR_W'(pos_x);
                        mem_req.raddr = ADDR_W'(pos_x);
                        key_in        = req_entry_key;
                        upd_in        = 1'b1;
                        state_in      = S_UPD_RD;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_POP_TOP: begin
            out_in        = rd_data;
            mem_req.raddr = ADDR_W'(count_ff);
            state_in      = S_POP_LAST;
         end
         S_POP_LAST: begin
            mov_in = rd_data;
            at_in  = '0;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DN_START;
            end
         end
         S_UPD_RD: begin
            mov_in = '{key: key_ff, tag: rd_data.tag};
            if (at_ff == '0) begin
               state_in = S_DN_START;
            end else begin
               mem_req.raddr = parent;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_START: begin
            if (at_ff == '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = at_ff;
               mem_req.wdata = mov_ff;
               state_in      = S_DONE;
            end else begin
               mem_req.raddr = parent;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (beats(mov_ff, rd_data, order_select)) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = at_ff;
               mem_req.wdata = rd_data;
               at_in         = parent;
               upd_in        = 1'b0;
               state_in      = S_UP_START;
            end else if (upd_ff) begin
               state_in = S_DN_START;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = at_ff;
               mem_req.wdata = mov_ff;
               state_in      = S_DONE;
            end
         end
         S_DN_START: begin
            if (left_x >= cnt_x) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = at_ff;
               mem_req.wdata = mov_ff;
               state_in      = S_DONE;
            end else begin
               mem_req.raddr = ADDR_W'(left_x);
               state_in      = S_DN_L;
            end
         end
         S_DN_L: begin
            if (right_x < cnt_x) begin
               child_in      = rd_data;
               mem_req.raddr = ADDR_W'(right_x);
               state_in      = S_DN_R;
            end else begin
               decide = 1'b1;
            end
         end
         S_DN_R: begin
            decide = 1'b1;
            if (beats(child_ff, rd_data, order_select)) begin
               cand = child_ff;
            end else begin
               cand     = rd_data;
               cand_idx = ADDR_W'(right_x);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_out_in    = out_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (decide) begin
         mem_req.we    = 1'b1;
         mem_req.waddr = at_ff;
         if (beats(cand, mov_ff, order_select)) begin
            mem_req.wdata = cand;
            at_in         = cand_idx;
            state_in      = S_DN_START;
         end else begin
            mem_req.wdata = mov_ff;
            state_in      = S_DONE;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_out_key = rsp_out_ff.key;
   assign rsp_out_tag = rsp_out_ff.tag;

   `BHPQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `BHPQ_ASSERT_IMPL(a_write_in_heap, clock, reset, mem_req.we, IDX_W'(mem_req.waddr) < cnt_x)
   `BHPQ_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `BHPQ_ASSERT_NEXT(a_pop_shrinks, clock, reset,
      accept && req_mode == MODE_POP && count_ff != '0,
      count_ff == CNT_W'($past(count_ff) - CNT_W'(1)))

endmodule

@@ rtl/binary_heap_priority_queue_top.sv @@
// Binary heap priority queue of (key, tag) entries with insert, pop and update.
// One transfer in, one result transfer out per item. Entries live in a single
// RAM with registered reads; each sift level costs a read and a compare, and a
// sift-down level with two children costs two reads through the single read
// port. Status errors finish soonest; the longest item is an update at the top
// of a full heap that sifts to the bottom, set by the sift-down loop. A finished
// result waits in an output register while the next item is taken. Register 0
// (byte address 0), bit 0: order select.
// Depends on bhpq_pkg, bhpq_ram and bhpq_ctrl.
module binary_heap_priority_queue_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [bhpq_pkg::KEY_WIDTH-1:0]  req_entry_key,
   input  logic [bhpq_pkg::TAG_WIDTH-1:0]  req_entry_tag,
   input  logic [bhpq_pkg::POS_WIDTH-1:0]  req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [bhpq_pkg::KEY_WIDTH-1:0]  rsp_out_key,
   output logic [bhpq_pkg::TAG_WIDTH-1:0]  rsp_out_tag,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bhpq_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import bhpq_pkg::*;

   logic        order_ff, order_in;
   logic        csr_hit;
   mem_req_type mem_req;
   entry_type   rd_data;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1] == REG_ORDER_SELECT);

   always_comb begin
      order_in = order_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         order_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
      end else begin
         order_ff <= order_in;
      end
   end

   assign csr_prdata = csr_hit ? 32'(order_ff) : '0;

   bhpq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .order_select  (order_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_entry_key (req_entry_key),
      .req_entry_tag (req_entry_tag),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_tag   (rsp_out_tag),
      .mem_req       (mem_req),
      .rd_data       (rd_data)
   );

   bhpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.raddr),
      .rd_data (rd_data)
   );

endmodule
